@@ src/assert_macros.svh @@
// Assertion macros used by the port checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted (reset active low).
`define OTQ_ASSERT(label, clk_sig, rst_sig, prop) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) \
        else $error("ordered timer queue check failed");

// Condition that must never be seen at a clock edge.
`define OTQ_ASSERT_NEVER(label, clk_sig, rst_sig, cond) \
    `OTQ_ASSERT(label, clk_sig, rst_sig, !(cond))

`endif

@@ src/otq_pkg.sv @@
// Types and codes shared by the timer queue and its checker.
package otq_pkg;

    localparam int TIME_W = 48;
    localparam int ID_W   = 32;
    localparam int REP_W  = 8;
    localparam int MS_W   = 24;

    typedef logic [TIME_W-1:0] tick_t;
    typedef logic [ID_W-1:0]   tid_t;
    typedef logic [REP_W-1:0]  rep_t;
    typedef logic [MS_W-1:0]   ms_t;

    typedef struct packed {
        tick_t expiry;
        tid_t  id;
        rep_t  reps;
    } entry_t;

    // request types
    localparam logic [1:0] REQ_ADD  = 2'd0;
    localparam logic [1:0] REQ_DEL  = 2'd1;
    localparam logic [1:0] REQ_TICK = 2'd2;
    localparam logic [1:0] REQ_NONE = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_DEL   = 2'd1;
    localparam logic [1:0] KIND_FIRED = 2'd2;
    localparam logic [1:0] KIND_TICK  = 2'd3;

    // result status
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

    // configuration register indexes
    localparam logic CFG_REPEAT_INTERVAL = 1'b0;
    localparam logic CFG_IDLE_SLEEP      = 1'b1;

    localparam ms_t REPEAT_RESET = 24'd1000;
    localparam ms_t IDLE_RESET   = 24'd3000;
    localparam ms_t SLEEP_MAX    = 24'hFFFFFF;

endpackage

@@ src/ordered_timer_queue_unit.sv @@
// Ordered timer queue: timer table in synchronous memory, scanned by deletes and ticks.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  cfg     | in        | cfg_wr_en          | cfg_index, cfg_data
//  in      | in        | in_valid, in_stall | req_type, delay_ms, repeat_count, target_id
//  out     | out       | out_valid,out_stall| kind, status, timer_id, repeats_left,
//          |           |                    | sleep_ms, last
//
// One request at a time; in_stall stays high until its last result is issued.
// A delete makes one full memory scan; a tick makes one scan per fired timer and a
// final one, since each search for the earliest timer reads every entry once.
// Results leave through a one-entry output register; out_stall holds the sequencer
// until that register frees up.
// Reset clears valid bits, clock, id counter and control state; sets config defaults.
module ordered_timer_queue_unit #(
    parameter int DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [23:0] delay_ms,
    input  logic [7:0]  repeat_count,
    input  logic [31:0] target_id,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [1:0]  status,
    output logic [31:0] timer_id,
    output logic [7:0]  repeats_left,
    output logic [23:0] sleep_ms,
    output logic        last
);

    localparam int IDXW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_ADD       = 3'd1;
    localparam logic [2:0] ST_DEL_SCAN  = 3'd2;
    localparam logic [2:0] ST_DEL_RESP  = 3'd3;
    localparam logic [2:0] ST_TICK_SCAN = 3'd4;
    localparam logic [2:0] ST_TICK_DEC  = 3'd5;

    // control state
    logic [2:0]         state_reg, state_next;
    otq_pkg::tick_t     now_reg, now_next;
    otq_pkg::tid_t      next_id_reg, next_id_next;
    otq_pkg::ms_t       rep_iv_reg, rep_iv_next;
    otq_pkg::ms_t       idle_reg, idle_next;
    logic [DEPTH-1:0]   valid_reg, valid_next;
    logic [CNTW-1:0]    scan_cnt_reg, scan_cnt_next;
    logic [CNTW-1:0]    fire_cnt_reg, fire_cnt_next;
    logic               rd_pend_reg, rd_pend_next;
    logic               best_valid_reg, best_valid_next;
    logic               hit_reg, hit_next;
    logic               out_valid_reg, out_valid_next;

    // payload
    otq_pkg::ms_t       req_delay_reg, req_delay_next;
    otq_pkg::rep_t      req_rep_reg, req_rep_next;
    otq_pkg::tid_t      req_target_reg, req_target_next;
    logic [IDXW-1:0]    rd_slot_reg, rd_slot_next;
    logic [IDXW-1:0]    best_slot_reg, best_slot_next;
    otq_pkg::entry_t    best_reg, best_next;
    logic [IDXW-1:0]    hit_slot_reg, hit_slot_next;
    logic [1:0]         kind_reg, kind_next;
    logic [1:0]         status_reg, status_next;
    otq_pkg::tid_t      timer_id_reg, timer_id_next;
    otq_pkg::rep_t      reps_out_reg, reps_out_next;
    otq_pkg::ms_t       sleep_reg, sleep_next;
    logic               last_reg, last_next;

    // table memory
    otq_pkg::entry_t    entry_mem [DEPTH];
    otq_pkg::entry_t    mem_q_reg;
    logic               mem_we;
    logic [IDXW-1:0]    mem_waddr;
    otq_pkg::entry_t    mem_wdata;
    logic [IDXW-1:0]    mem_raddr;

    logic               free_found;
    logic [IDXW-1:0]    free_slot;
    logic               out_free;
    logic               in_acc;
    logic               cand_better;
    logic               due;
    otq_pkg::ms_t       iv_eff;
    otq_pkg::tick_t     diff;
    otq_pkg::ms_t       sleep_val;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
        mem_q_reg <= entry_mem[mem_raddr];
    end

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_slot  = IDXW'(i);
            end
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign in_acc   = in_valid && (state_reg == ST_IDLE);
    assign iv_eff   = (rep_iv_reg == '0) ? 24'd1 : rep_iv_reg;

    // earlier expiry wins, then lower id; equal keys keep the lower slot
    assign cand_better = valid_reg[rd_slot_reg] &&
        (!best_valid_reg || (mem_q_reg.expiry < best_reg.expiry) ||
         ((mem_q_reg.expiry == best_reg.expiry) && (mem_q_reg.id < best_reg.id)));

    assign due = best_valid_reg && (best_reg.expiry <= now_reg) &&
                 (fire_cnt_reg != CNTW'(DEPTH));

    assign diff = best_reg.expiry - now_reg;

    always_comb
    begin
        if (!best_valid_reg)
        begin
            sleep_val = idle_reg;
        end
        else if (best_reg.expiry > now_reg)
        begin
            sleep_val = (diff[47:24] != '0) ? otq_pkg::SLEEP_MAX : diff[23:0];
        end
        else
        begin
            sleep_val = '0;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        now_next        = now_reg;
        next_id_next    = next_id_reg;
        rep_iv_next     = rep_iv_reg;
        idle_next       = idle_reg;
        valid_next      = valid_reg;
        scan_cnt_next   = scan_cnt_reg;
        fire_cnt_next   = fire_cnt_reg;
        rd_pend_next    = 1'b0;
        best_valid_next = best_valid_reg;
        hit_next        = hit_reg;
        out_valid_next  = out_valid_reg && out_stall;
        req_delay_next  = req_delay_reg;
        req_rep_next    = req_rep_reg;
        req_target_next = req_target_reg;
        rd_slot_next    = rd_slot_reg;
        best_slot_next  = best_slot_reg;
        best_next       = best_reg;
        hit_slot_next   = hit_slot_reg;
        kind_next       = kind_reg;
        status_next     = status_reg;
        timer_id_next   = timer_id_reg;
        reps_out_next   = reps_out_reg;
        sleep_next      = sleep_reg;
        last_next       = last_reg;
        mem_we          = 1'b0;
        mem_waddr       = free_slot;
        mem_wdata       = '0;
        mem_raddr       = scan_cnt_reg[IDXW-1:0];

        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                otq_pkg::CFG_REPEAT_INTERVAL: rep_iv_next = cfg_data;
                otq_pkg::CFG_IDLE_SLEEP:      idle_next   = cfg_data;
            endcase
        end

        // issue one table read per cycle while a scan runs
        if ((state_reg == ST_DEL_SCAN || state_reg == ST_TICK_SCAN) &&
            (scan_cnt_reg != CNTW'(DEPTH)))
        begin
            rd_pend_next  = 1'b1;
            rd_slot_next  = scan_cnt_reg[IDXW-1:0];
            scan_cnt_next = scan_cnt_reg + 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    req_delay_next  = delay_ms;
                    req_rep_next    = repeat_count;
                    req_target_next = target_id;
                    scan_cnt_next   = '0;
                    best_valid_next = 1'b0;
                    hit_next        = 1'b0;
                    fire_cnt_next   = '0;
                    case (req_type)
                        otq_pkg::REQ_ADD:  state_next = ST_ADD;
                        otq_pkg::REQ_DEL:  state_next = ST_DEL_SCAN;
                        otq_pkg::REQ_TICK:
                        begin
                            now_next   = now_reg + 1'b1;
                            state_next = ST_TICK_SCAN;
                        end
                        default:           state_next = ST_IDLE;
                    endcase
                end
            end

            ST_ADD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = otq_pkg::KIND_ADD;
                    reps_out_next  = '0;
                    sleep_next     = '0;
                    last_next      = 1'b1;
                    if (free_found)
                    begin
                        mem_we                = 1'b1;
                        mem_waddr             = free_slot;
                        mem_wdata.expiry      = now_reg + otq_pkg::TIME_W'(req_delay_reg);
                        mem_wdata.id          = next_id_reg;
                        mem_wdata.reps        = req_rep_reg;
                        valid_next[free_slot] = 1'b1;
                        next_id_next          = next_id_reg + 1'b1;
                        status_next           = otq_pkg::STAT_OK;
                        timer_id_next         = next_id_reg;
                    end
                    else
                    begin
                        status_next   = otq_pkg::STAT_FULL;
                        timer_id_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_DEL_SCAN:
            begin
                if (rd_pend_reg && !hit_reg && valid_reg[rd_slot_reg] &&
                    (mem_q_reg.id == req_target_reg))
                begin
                    hit_next      = 1'b1;
                    hit_slot_next = rd_slot_reg;
                end
                if ((scan_cnt_reg == CNTW'(DEPTH)) && !rd_pend_reg)
                begin
                    state_next = ST_DEL_RESP;
                end
            end

            ST_DEL_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = otq_pkg::KIND_DEL;
                    status_next    = hit_reg ? otq_pkg::STAT_OK : otq_pkg::STAT_NOT_FOUND;
                    timer_id_next  = req_target_reg;
                    reps_out_next  = '0;
                    sleep_next     = '0;
                    last_next      = 1'b1;
                    if (hit_reg)
                    begin
                        valid_next[hit_slot_reg] = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_TICK_SCAN:
            begin
                if (rd_pend_reg && cand_better)
                begin
                    best_valid_next = 1'b1;
                    best_slot_next  = rd_slot_reg;
                    best_next       = mem_q_reg;
                end
                if ((scan_cnt_reg == CNTW'(DEPTH)) && !rd_pend_reg)
                begin
                    state_next = ST_TICK_DEC;
                end
            end

            ST_TICK_DEC:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = otq_pkg::STAT_OK;
                    if (due)
                    begin
                        kind_next     = otq_pkg::KIND_FIRED;
                        timer_id_next = best_reg.id;
                        reps_out_next = best_reg.reps;
                        sleep_next    = '0;
                        last_next     = 1'b0;
                        if (best_reg.reps == 8'd1)
                        begin
                            valid_next[best_slot_reg] = 1'b0;
                        end
                        else
                        begin
                            // re-arm in place with a fresh id
                            mem_we           = 1'b1;
                            mem_waddr        = best_slot_reg;
                            mem_wdata.expiry = now_reg + otq_pkg::TIME_W'(iv_eff);
                            mem_wdata.id     = next_id_reg;
                            mem_wdata.reps   = (best_reg.reps == '0) ? '0 :
                                               best_reg.reps - 1'b1;
                            next_id_next     = next_id_reg + 1'b1;
                        end
                        fire_cnt_next   = fire_cnt_reg + 1'b1;
                        scan_cnt_next   = '0;
                        best_valid_next = 1'b0;
                        state_next      = ST_TICK_SCAN;
                    end
                    else
                    begin
                        kind_next     = otq_pkg::KIND_TICK;
                        timer_id_next = '0;
                        reps_out_next = '0;
                        sleep_next    = sleep_val;
                        last_next     = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            now_reg        <= '0;
            next_id_reg    <= '0;
            rep_iv_reg     <= otq_pkg::REPEAT_RESET;
            idle_reg       <= otq_pkg::IDLE_RESET;
            valid_reg      <= '0;
            scan_cnt_reg   <= '0;
            fire_cnt_reg   <= '0;
            rd_pend_reg    <= 1'b0;
            best_valid_reg <= 1'b0;
            hit_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            now_reg        <= now_next;
            next_id_reg    <= next_id_next;
            rep_iv_reg     <= rep_iv_next;
            idle_reg       <= idle_next;
            valid_reg      <= valid_next;
            scan_cnt_reg   <= scan_cnt_next;
            fire_cnt_reg   <= fire_cnt_next;
            rd_pend_reg    <= rd_pend_next;
            best_valid_reg <= best_valid_next;
            hit_reg        <= hit_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_delay_reg  <= req_delay_next;
        req_rep_reg    <= req_rep_next;
        req_target_reg <= req_target_next;
        rd_slot_reg    <= rd_slot_next;
        best_slot_reg  <= best_slot_next;
        best_reg       <= best_next;
        hit_slot_reg   <= hit_slot_next;
        kind_reg       <= kind_next;
        status_reg     <= status_next;
        timer_id_reg   <= timer_id_next;
        reps_out_reg   <= reps_out_next;
        sleep_reg      <= sleep_next;
        last_reg       <= last_next;
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign status       = status_reg;
    assign timer_id     = timer_id_reg;
    assign repeats_left = reps_out_reg;
    assign sleep_ms     = sleep_reg;
    assign last         = last_reg;

endmodule

@@ src/otq_checker.sv @@
// Port-level checks for the timer queue, bound to the top level.
`include "assert_macros.svh"

module otq_port_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [1:0]  req_type,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  kind,
    input logic [31:0] timer_id,
    input logic [23:0] sleep_ms,
    input logic        last
);

    logic fired_out;
    logic tick_out;
    logic req_acc;

    assign fired_out = out_valid && (kind == otq_pkg::KIND_FIRED);
    assign tick_out  = out_valid && (kind == otq_pkg::KIND_TICK);
    assign req_acc   = in_valid && !in_stall && (req_type != otq_pkg::REQ_NONE);

    // a fired timer is never the closing result of a tick
    `OTQ_ASSERT_NEVER(a_fired_not_last, clk, rst_n, fired_out && last)

    // every other result kind closes its request
    `OTQ_ASSERT(a_close_last, clk, rst_n, (out_valid && !fired_out) |-> last)

    // a real request raises in_stall after acceptance, holding off the next one
    `OTQ_ASSERT(a_busy_after_req, clk, rst_n, req_acc |=> in_stall)

    // sleep time only rides on the tick-done result
    `OTQ_ASSERT(a_sleep_on_tick, clk, rst_n, (out_valid && !tick_out) |-> sleep_ms == 24'd0)

    // stalled result holds
    `OTQ_ASSERT(a_out_hold, clk, rst_n, (out_valid && out_stall) |=> (out_valid && $stable(timer_id)))

endmodule

bind ordered_timer_queue_unit otq_port_checker u_otq_checker (.*);
